/* rtl/vpw_pkg.sv */
`default_nettype none

package vpw_pkg;

  // default plane size in bytes
  localparam int PLANE_BYTES_DEF = 65536;

  // configuration port geometry
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_WRITE_MODE       = 3'd0,
    REG_ROTATE_COUNT     = 3'd1,
    REG_LOGIC_OP         = 3'd2,
    REG_SET_RESET_BITS   = 3'd3,
    REG_ENABLE_SET_RESET = 3'd4,
    REG_PIXEL_MASK       = 3'd5,
    REG_READ_PLANE       = 3'd6,
    REG_PLANE_WRITE_MASK = 3'd7
  } reg_idx_t;

  // write modes
  typedef enum logic [1:0] {
    WM_ROTATE   = 2'd0,
    WM_LATCH    = 2'd1,
    WM_EXPAND   = 2'd2,
    WM_MASKED   = 2'd3
  } write_mode_t;

  // logic operations against the latches
  typedef enum logic [1:0] {
    LOP_REPLACE = 2'd0,
    LOP_AND     = 2'd1,
    LOP_OR      = 2'd2,
    LOP_XOR     = 2'd3
  } logic_op_t;

  // reset values of the mask registers
  localparam logic [7:0] PIXEL_MASK_RST = 8'hFF;
  localparam logic [3:0] PLANE_MASK_RST = 4'hF;

  // graphics controller register file contents
  typedef struct packed {
    write_mode_t write_mode;
    logic [2:0]  rotate_count;
    logic_op_t   logic_op;
    logic [3:0]  set_reset_bits;
    logic [3:0]  enable_set_reset;
    logic [7:0]  pixel_mask;
    logic [1:0]  read_plane;
    logic [3:0]  plane_write_mask;
  } cfg_t;

  // memory access request control
  typedef struct packed {
    logic       en;
    logic       wr;
    logic [3:0] be;
  } mem_req_t;

endpackage

`default_nettype wire

/* rtl/vpw_cfg_regs.sv */
`default_nettype none

module vpw_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [vpw_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [vpw_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [vpw_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                pready,
  output vpw_pkg::cfg_t                       cfg
);

  vpw_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx    = vpw_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.write_mode       <= vpw_pkg::WM_ROTATE;
      cfg.rotate_count     <= '0;
      cfg.logic_op         <= vpw_pkg::LOP_REPLACE;
      cfg.set_reset_bits   <= '0;
      cfg.enable_set_reset <= '0;
      cfg.pixel_mask       <= vpw_pkg::PIXEL_MASK_RST;
      cfg.read_plane       <= '0;
      cfg.plane_write_mask <= vpw_pkg::PLANE_MASK_RST;
    end else if (wr_en) begin
      unique case (idx)
        vpw_pkg::REG_WRITE_MODE:       cfg.write_mode <= vpw_pkg::write_mode_t'(pwdata[1:0]);
        vpw_pkg::REG_ROTATE_COUNT:     cfg.rotate_count <= pwdata[2:0];
        vpw_pkg::REG_LOGIC_OP:         cfg.logic_op <= vpw_pkg::logic_op_t'(pwdata[1:0]);
        vpw_pkg::REG_SET_RESET_BITS:   cfg.set_reset_bits <= pwdata[3:0];
        vpw_pkg::REG_ENABLE_SET_RESET: cfg.enable_set_reset <= pwdata[3:0];
        vpw_pkg::REG_PIXEL_MASK:       cfg.pixel_mask <= pwdata[7:0];
        vpw_pkg::REG_READ_PLANE:       cfg.read_plane <= pwdata[1:0];
        vpw_pkg::REG_PLANE_WRITE_MASK: cfg.plane_write_mask <= pwdata[3:0];
      endcase
    end
  end

  // register reads
  always_comb begin
    prdata = '0;
    unique case (idx)
      vpw_pkg::REG_WRITE_MODE:       prdata[1:0] = cfg.write_mode;
      vpw_pkg::REG_ROTATE_COUNT:     prdata[2:0] = cfg.rotate_count;
      vpw_pkg::REG_LOGIC_OP:         prdata[1:0] = cfg.logic_op;
      vpw_pkg::REG_SET_RESET_BITS:   prdata[3:0] = cfg.set_reset_bits;
      vpw_pkg::REG_ENABLE_SET_RESET: prdata[3:0] = cfg.enable_set_reset;
      vpw_pkg::REG_PIXEL_MASK:       prdata[7:0] = cfg.pixel_mask;
      vpw_pkg::REG_READ_PLANE:       prdata[1:0] = cfg.read_plane;
      vpw_pkg::REG_PLANE_WRITE_MASK: prdata[3:0] = cfg.plane_write_mask;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/vpw_write_path.sv */
`default_nettype none

module vpw_write_path (
  input  wire vpw_pkg::cfg_t cfg,
  input  wire logic [7:0]    data,
  input  wire logic [31:0]   latches,
  output logic      [31:0]   wdata,
  output logic      [3:0]    be
);

  logic [7:0]  rot;
  logic [15:0] dbl;
  logic [7:0]  data_in;
  logic [7:0]  bits;

  // rotate right by rotate_count, skipped in mode 2
  assign dbl     = {data, data};
  assign rot     = 8'(dbl >> cfg.rotate_count);
  assign data_in = (cfg.write_mode == vpw_pkg::WM_EXPAND) ? data : rot;

  // bit mask, narrowed by the data in mode 3
  assign bits = (cfg.write_mode == vpw_pkg::WM_MASKED) ? (cfg.pixel_mask & data_in)
                                                       : cfg.pixel_mask;

  assign be = cfg.plane_write_mask;

  // per plane source, logic op and bit mask merge; mode 1 writes the latches back
  always_comb begin
    logic [7:0] lat;
    logic [7:0] src;
    logic [7:0] val;
    wdata = '0;
    for (int p = 0; p < 4; p++) begin
      lat = latches[8*p +: 8];
      if (cfg.write_mode == vpw_pkg::WM_EXPAND) begin
        src = {8{data_in[p]}};
      end else if (cfg.write_mode == vpw_pkg::WM_MASKED || cfg.enable_set_reset[p]) begin
        src = {8{cfg.set_reset_bits[p]}};
      end else begin
        src = data_in;
      end
      unique case (cfg.logic_op)
        vpw_pkg::LOP_AND:     val = src & lat;
        vpw_pkg::LOP_OR:      val = src | lat;
        vpw_pkg::LOP_XOR:     val = src ^ lat;
        vpw_pkg::LOP_REPLACE: val = src;
      endcase
      val = (val & bits) | (lat & ~bits);
      if (cfg.write_mode == vpw_pkg::WM_LATCH) begin
        val = lat;
      end
      wdata[8*p +: 8] = val;
    end
  end

endmodule

`default_nettype wire

/* rtl/vpw_plane_mem.sv */
`default_nettype none

module vpw_plane_mem #(
  parameter int PLANE_BYTES = vpw_pkg::PLANE_BYTES_DEF,
  localparam int AddrW = $clog2(PLANE_BYTES)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire vpw_pkg::mem_req_t req,
  input  wire logic [AddrW-1:0]  addr,
  input  wire logic [31:0]       wdata,
  output logic      [31:0]       latches,
  output logic                   clearing
);

  logic [31:0]      mem [PLANE_BYTES];
  logic [AddrW-1:0] clr_addr;

  // clearing pass after reset, one word a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AddrW'(PLANE_BYTES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // word write with per-plane byte enables
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (req.en && req.wr) begin
      for (int p = 0; p < 4; p++) begin
        if (req.be[p]) begin
          mem[addr][8*p +: 8] <= wdata[8*p +: 8];
        end
      end
    end
  end

  // registered read doubles as the plane latches
  always_ff @(posedge clk) begin
    if (rst) begin
      latches <= '0;
    end else if (req.en && !req.wr) begin
      latches <= mem[addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/vga_planar_write_latch_unit.sv */
// VGA planar write/latch unit: four 8-bit planes kept side by side in one
// 32-bit word per offset, with graphics controller write modes 0 to 3.
// Input channel (in_valid/in_ready): one access per item, mode 0 read,
// 1 write, at address taken modulo PLANE_BYTES; write_data used on writes.
// Output channel (out_valid/out_ready): one item per access; read_data is the
// latch byte of read_plane on a read and zero on a write.
// Configuration: APB-style port, registers at byte address 4*index, always
// ready; write it only while the block is idle.
// Path: an accepted item goes through the input register, then the plane memory
// access, after which its result is valid.
// Throughput: one item per cycle while out_ready is high; the single memory
// port does one read or one byte-enabled write each cycle, and a write uses
// the latches left by the most recent read.
// Reset: registers take their reset values, latches clear, then a clearing
// pass writes zero to all PLANE_BYTES words, one a cycle, with in_ready low;
// configuration writes are still taken.
// Stall: while out_ready is low the result holds, the input register keeps
// one more item and in_ready drops once it is full.
`default_nettype none

module vga_planar_write_latch_unit #(
  parameter int PLANE_BYTES = vpw_pkg::PLANE_BYTES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           mode,
  input  wire logic [15:0]                    address,
  input  wire logic [7:0]                     write_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [7:0]                     read_data,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [vpw_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [vpw_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [vpw_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                pready
);

  localparam int AddrW = $clog2(PLANE_BYTES);
  localparam int RemW  = 21;

  vpw_pkg::cfg_t     cfg;
  vpw_pkg::mem_req_t req;

  logic             v1;
  logic             mode1;
  logic [15:0]      addr1;
  logic [7:0]       data1;
  logic             v2;
  logic             kind2;
  logic             adv1;
  logic             clearing;
  logic [RemW-1:0]  rem;
  logic [AddrW-1:0] mem_addr;
  logic [31:0]      wdata;
  logic [3:0]       be;
  logic [31:0]      latches;

  vpw_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // handshake and stage advance
  assign adv1     = v1 && (!v2 || out_ready);
  assign in_ready = !clearing && (!v1 || adv1);

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (in_valid && in_ready) begin
      v1 <= 1'b1;
    end else if (adv1) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode1 <= mode;
      addr1 <= address;
      data1 <= write_data;
    end
  end

  // address modulo plane size by conditional subtraction
  always_comb begin
    rem = RemW'(addr1);
    for (int k = 4; k >= 0; k--) begin
      if (rem >= (RemW'(PLANE_BYTES) << k)) begin
        rem = rem - (RemW'(PLANE_BYTES) << k);
      end
    end
  end
  assign mem_addr = rem[AddrW-1:0];

  vpw_write_path u_wpath (
    .cfg     (cfg),
    .data    (data1),
    .latches (latches),
    .wdata   (wdata),
    .be      (be)
  );

  assign req.en = adv1;
  assign req.wr = mode1;
  assign req.be = be;

  vpw_plane_mem #(
    .PLANE_BYTES (PLANE_BYTES)
  ) u_mem (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .addr     (mem_addr),
    .wdata    (wdata),
    .latches  (latches),
    .clearing (clearing)
  );

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv1) begin
      v2 <= 1'b1;
    end else if (out_ready) begin
      v2 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      kind2 <= mode1;
    end
  end

  assign out_valid = v2;
  assign read_data = kind2 ? 8'h00 : latches[8*cfg.read_plane +: 8];

  // no item in flight during the clearing pass
  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!v1 && !v2))
    else $error("item in flight during clearing pass");

  // an advancing item always lands in the result stage
  a_adv_lands: assert property (@(posedge clk) disable iff (rst)
    adv1 |=> v2)
    else $error("advanced item lost");

  // latches hold while a read result waits
  a_latch_hold: assert property (@(posedge clk) disable iff (rst)
    (v2 && !out_ready && !kind2) |=> $stable(latches))
    else $error("latches changed under a pending read result");

endmodule

`default_nettype wire
